>>> rtl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared widths, constants and types of the NTC Beta temperature converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int FS_W        = 16;
	localparam int DEFAULT_FULL_SCALE = 4095;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 20;
	localparam int BETA_W      = 16;
	localparam int RES_W       = 20;
	localparam int T0_W        = 16;

	localparam int LOG_IN_W    = 20;
	localparam int LOG_EXP_W   = 5;
	localparam int LOG_FRAC    = 16;
	localparam int LOG_OUT_W   = LOG_EXP_W + LOG_FRAC;
	localparam int MANT_W      = 31;
	localparam int LOG_LAT     = LOG_FRAC + 1;

	localparam int L2_W        = LOG_OUT_W + 2;
	localparam int MAG_W       = LOG_OUT_W + 1;
	localparam int LN2_W       = 32;
	localparam int PROD_W      = MAG_W + LN2_W;
	localparam int LN_W        = MAG_W + 1;
	localparam int T0LN_W      = T0_W + 1 + LN_W;
	localparam int CENTI       = 100;
	localparam int BETA100_W   = BETA_W + 7;
	localparam int BT_W        = BETA_W + T0_W;
	localparam int N_W         = BT_W + 7 + LOG_FRAC;
	localparam int D_W         = T0LN_W + 1;
	localparam int DEN_W       = D_W - 1;
	localparam int NUM_W       = N_W + 1;
	localparam int QUO_W       = 17;
	localparam int DIV_LAT     = QUO_W + 1;
	localparam int LANE_LAT    = LOG_LAT + 4 + DIV_LAT + 1;

	localparam int TEMP_W      = 18;

	localparam logic [LN2_W-1:0]          LN2_Q32      = 32'd2977044472;
	localparam logic signed [TEMP_W-1:0]  TEMP_INVALID = -18'sd27315;
	localparam logic signed [TEMP_W-1:0]  TEMP_MAX     = 18'sd100000;
	localparam logic [QUO_W-1:0]          TC_MAX       = 17'd127315;
	localparam logic [QUO_W-1:0]          ZERO_C       = 17'd27315;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BETA = 3'd0,
		REG_R0   = 3'd1,
		REG_T0   = 3'd2,
		REG_RS   = 3'd3,
		REG_EN0  = 3'd4,
		REG_EN1  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [T0_W-1:0]      t0;
		logic [BETA100_W-1:0] beta100;
		logic [N_W-1:0]       n;
		logic                 regs_ok;
	} ntc_cfg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic                     vld;
	} lane_res_t;

endpackage

>>> rtl/ntc_beta_temperature_convert.sv
// ----------------------------------------------------------------------------
// ntc_beta_temperature_convert
// Two-channel NTC thermistor to temperature converter using the Beta equation.
// ----------------------------------------------------------------------------
// A word (two ADC samples) is taken on any cycle with start high; busy stays
// low, so one word per clock is accepted. Results appear on temp_ch0/temp_ch1
// and valid_ch0/valid_ch1 for one cycle with done high; the latency comes mostly
// from the 16 squaring stages of the log2 units and the 17 quotient-bit divider stages.
// The receiver cannot stall. Configuration may only change while no word is
// in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_convert import ntc_pkg::*; #(
	parameter int ADC_FULL_SCALE = DEFAULT_FULL_SCALE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [SAMPLE_W-1:0]         sample_ch0,
	input  logic [SAMPLE_W-1:0]         sample_ch1,
	output logic                        done,
	output logic signed [TEMP_W-1:0]    temp_ch0,
	output logic                        valid_ch0,
	output logic signed [TEMP_W-1:0]    temp_ch1,
	output logic                        valid_ch1,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data
);

	logic [BETA_W-1:0]    beta_q;
	logic [RES_W-1:0]     r0_q;
	logic [T0_W-1:0]      t0_q;
	logic [RES_W-1:0]     rs_q;
	logic                 en0_q, en1_q;
	logic [BT_W-1:0]      bt_q;
	logic [N_W-1:0]       n_q;
	logic [BETA100_W-1:0] beta100_q;
	ntc_cfg_t             cfg;
	logic [LOG_OUT_W-1:0] log_rs, log_r0;
	lane_res_t            res0, res1;
	logic                 vld_q [0:LANE_LAT];
	logic signed [TEMP_W-1:0] temp0_q, temp1_q;
	logic                 v0_q, v1_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_W'(3950);
			r0_q   <= RES_W'(10000);
			t0_q   <= T0_W'(29815);
			rs_q   <= RES_W'(10000);
			en0_q  <= 1'b1;
			en1_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BETA: beta_q <= cfg_data[BETA_W-1:0];
				REG_R0:   r0_q   <= cfg_data[RES_W-1:0];
				REG_T0:   t0_q   <= cfg_data[T0_W-1:0];
				REG_RS:   rs_q   <= cfg_data[RES_W-1:0];
				REG_EN0:  en0_q  <= cfg_data[0];
				REG_EN1:  en1_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// derived constants, settle long before an item reaches them
	always_ff @(posedge clk) begin
		bt_q      <= BT_W'(beta_q) * BT_W'(t0_q);
		n_q       <= {(BT_W+7)'((BT_W+7)'(bt_q) * (BT_W+7)'(CENTI)), {LOG_FRAC{1'b0}}};
		beta100_q <= BETA100_W'(beta_q) * BETA100_W'(CENTI);
	end

	assign cfg.t0      = t0_q;
	assign cfg.beta100 = beta100_q;
	assign cfg.n       = n_q;
	assign cfg.regs_ok = (beta_q != '0) && (r0_q != '0) && (t0_q != '0) && (rs_q != '0);

	ntc_log2 u_log_rs (.clk(clk), .x(rs_q), .r(log_rs));
	ntc_log2 u_log_r0 (.clk(clk), .x(r0_q), .r(log_r0));

	ntc_lane #(.FULL_SCALE(ADC_FULL_SCALE)) u_lane0 (
		.clk(clk), .en(en0_q), .sample(sample_ch0), .cfg(cfg),
		.log_rs(log_rs), .log_r0(log_r0), .res(res0)
	);

	ntc_lane #(.FULL_SCALE(ADC_FULL_SCALE)) u_lane1 (
		.clk(clk), .en(en1_q), .sample(sample_ch1), .cfg(cfg),
		.log_rs(log_rs), .log_r0(log_r0), .res(res1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LANE_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i <= LANE_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		temp0_q <= res0.temp;
		v0_q    <= res0.vld;
		temp1_q <= res1.temp;
		v1_q    <= res1.vld;
	end

	assign done      = vld_q[LANE_LAT];
	assign temp_ch0  = temp0_q;
	assign valid_ch0 = v0_q;
	assign temp_ch1  = temp1_q;
	assign valid_ch1 = v1_q;

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LANE_LAT + 1))
		else $error("done without matching start");

	a_invalid_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_ch0) |-> (temp_ch0 == TEMP_INVALID))
		else $error("channel 0 invalid word carries a temperature");

	a_invalid_ch1: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !valid_ch1) |-> (temp_ch1 == TEMP_INVALID))
		else $error("channel 1 invalid word carries a temperature");

	a_range_ch0: assert property (@(posedge clk) disable iff (!arst_n)
		(done && valid_ch0) |-> ((temp_ch0 <= TEMP_MAX) && (temp_ch0 >= TEMP_INVALID)))
		else $error("channel 0 temperature out of range");
`endif

endmodule

>>> rtl/ntc_log2.sv
// ----------------------------------------------------------------------------
// ntc_log2
// Pipelined log2 in Q.16: leading-one exponent, then 16 squaring stages.
// ----------------------------------------------------------------------------
module ntc_log2 import ntc_pkg::*; (
	input  logic                 clk,
	input  logic [LOG_IN_W-1:0]  x,
	output logic [LOG_OUT_W-1:0] r
);

	logic [LOG_EXP_W-1:0] lead;
	logic [MANT_W-1:0]    m_q [0:LOG_FRAC];
	logic [LOG_EXP_W-1:0] e_q [0:LOG_FRAC];
	logic [LOG_FRAC-1:0]  f_q [0:LOG_FRAC];

	always_comb begin
		lead = '0;
		for (int i = 0; i < LOG_IN_W; i++) begin
			if (x[i]) begin
				lead = LOG_EXP_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		m_q[0] <= MANT_W'(x) << (LOG_EXP_W'(MANT_W - 1) - lead);
		e_q[0] <= lead;
		f_q[0] <= '0;
	end

	for (genvar s = 0; s < LOG_FRAC; s++) begin : g_sq
		logic [2*MANT_W-1:0] sq;
		logic [MANT_W:0]     m2;

		assign sq = (2*MANT_W)'(m_q[s]) * (2*MANT_W)'(m_q[s]);
		assign m2 = sq[2*MANT_W-1 -: MANT_W+1];

		always_ff @(posedge clk) begin
			if (m2[MANT_W]) begin
				m_q[s+1] <= m2[MANT_W:1];
			end else begin
				m_q[s+1] <= m2[MANT_W-1:0];
			end
			e_q[s+1] <= e_q[s];
			f_q[s+1] <= f_q[s] | (LOG_FRAC'(m2[MANT_W]) << (LOG_FRAC - 1 - s));
		end
	end

	assign r = {e_q[LOG_FRAC], f_q[LOG_FRAC]};

endmodule

>>> rtl/ntc_div.sv
// ----------------------------------------------------------------------------
// ntc_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module ntc_div import ntc_pkg::*; (
	input  logic              clk,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	output logic [QUO_W-1:0]  q,
	output logic              ovf
);

	localparam int REM_W = DEN_W + QUO_W;

	logic [REM_W-1:0] rem_q [0:QUO_W];
	logic [DEN_W-1:0] den_q [0:QUO_W];
	logic [QUO_W-1:0] q_q   [0:QUO_W];
	logic             ovf_q [0:QUO_W];

	always_ff @(posedge clk) begin
		rem_q[0] <= REM_W'(num);
		den_q[0] <= den;
		q_q[0]   <= '0;
		ovf_q[0] <= REM_W'(num) >= {den, {QUO_W{1'b0}}};
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [REM_W-1:0] dsh;
		logic             ge;

		assign dsh = REM_W'(den_q[k]) << (QUO_W - 1 - k);
		assign ge  = rem_q[k] >= dsh;

		always_ff @(posedge clk) begin
			rem_q[k+1] <= ge ? rem_q[k] - dsh : rem_q[k];
			den_q[k+1] <= den_q[k];
			q_q[k+1]   <= {q_q[k][QUO_W-2:0], ge};
			ovf_q[k+1] <= ovf_q[k];
		end
	end

	assign q   = q_q[QUO_W];
	assign ovf = ovf_q[QUO_W];

endmodule

>>> rtl/ntc_lane.sv
// ----------------------------------------------------------------------------
// ntc_lane
// One channel: range check, log ratio, ln scaling, Beta denominator, divide.
// ----------------------------------------------------------------------------
module ntc_lane import ntc_pkg::*; #(
	parameter int FULL_SCALE = DEFAULT_FULL_SCALE
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SAMPLE_W-1:0]  sample,
	input  ntc_cfg_t             cfg,
	input  logic [LOG_OUT_W-1:0] log_rs,
	input  logic [LOG_OUT_W-1:0] log_r0,
	output lane_res_t            res
);

	localparam logic [FS_W-1:0] FS = FS_W'(FULL_SCALE);

	logic                 ok_in;
	logic [FS_W-1:0]      fa;
	logic [LOG_OUT_W-1:0] log_a;
	logic [LOG_OUT_W-1:0] log_fa;
	logic                 ok_q [0:LOG_LAT-1];

	logic signed [L2_W-1:0]   l2;
	logic [MAG_W-1:0]         mag_s1;
	logic                     neg_s1, ok_s1;
	logic [PROD_W-1:0]        prod_s2;
	logic                     neg_s2, ok_s2;
	logic [PROD_W:0]          rnd;
	logic signed [LN_W-1:0]   lnq;
	logic signed [T0LN_W-1:0] t0ln_s3;
	logic                     ok_s3;
	logic signed [D_W-1:0]    d;
	logic [NUM_W-1:0]         num_s4;
	logic [DEN_W-1:0]         den_s4;
	logic                     dpos_s4, ok_s4;
	logic [QUO_W-1:0]         q;
	logic                     ovf;
	logic [1:0]               fl_q [0:DIV_LAT-1];
	lane_res_t                res_q;

	assign ok_in = en && (sample != '0) && (FS_W'(sample) < FS) && cfg.regs_ok;
	assign fa    = FS - FS_W'(sample);

	ntc_log2 u_log_a (.clk(clk), .x(LOG_IN_W'(sample)), .r(log_a));
	ntc_log2 u_log_fa (.clk(clk), .x(LOG_IN_W'(fa)), .r(log_fa));

	always_ff @(posedge clk) begin
		ok_q[0] <= ok_in;
		for (int i = 1; i < LOG_LAT; i++) begin
			ok_q[i] <= ok_q[i-1];
		end
	end

	assign l2 = $signed({2'b00, log_rs}) + $signed({2'b00, log_a})
		- $signed({2'b00, log_fa}) - $signed({2'b00, log_r0});

	always_ff @(posedge clk) begin
		mag_s1 <= l2[L2_W-1] ? MAG_W'(-l2) : MAG_W'(l2);
		neg_s1 <= l2[L2_W-1];
		ok_s1  <= ok_q[LOG_LAT-1];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(LN2_Q32);
		neg_s2  <= neg_s1;
		ok_s2   <= ok_s1;
	end

	assign rnd = {1'b0, prod_s2} + ((PROD_W+1)'(1) << (LN2_W - 1));
	assign lnq = neg_s2 ? -$signed({1'b0, rnd[LN2_W +: MAG_W]})
		: $signed({1'b0, rnd[LN2_W +: MAG_W]});

	always_ff @(posedge clk) begin
		t0ln_s3 <= $signed({1'b0, cfg.t0}) * lnq;
		ok_s3   <= ok_s2;
	end

	assign d = $signed({2'b00, cfg.beta100, {LOG_FRAC{1'b0}}}) + D_W'(t0ln_s3);

	always_ff @(posedge clk) begin
		num_s4  <= NUM_W'(cfg.n) + NUM_W'(d[DEN_W-1:1]);
		den_s4  <= d[DEN_W-1:0];
		dpos_s4 <= !d[D_W-1] && (d != '0);
		ok_s4   <= ok_s3;
	end

	ntc_div u_div (.clk(clk), .num(num_s4), .den(den_s4), .q(q), .ovf(ovf));

	always_ff @(posedge clk) begin
		fl_q[0] <= {ok_s4, dpos_s4};
		for (int i = 1; i < DIV_LAT; i++) begin
			fl_q[i] <= fl_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (!fl_q[DIV_LAT-1][1]) begin
			res_q.temp <= TEMP_INVALID;
			res_q.vld  <= 1'b0;
		end else if (!fl_q[DIV_LAT-1][0] || ovf || (q > TC_MAX)) begin
			res_q.temp <= TEMP_MAX;
			res_q.vld  <= 1'b1;
		end else begin
			res_q.temp <= $signed(TEMP_W'(q) - TEMP_W'(ZERO_C));
			res_q.vld  <= 1'b1;
		end
	end

	assign res = res_q;

endmodule

>>> tb/tb_ntc_beta_temperature_convert.sv
// ----------------------------------------------------------------------------
// tb_ntc_beta_temperature_convert
// Self-checking testbench: drives sample words with random gaps, predicts
// each channel with a bit-exact fixed-point Beta model and checks every
// result word in order. Runs directed corner cases, then random phases over
// several register settings including the extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ntc_beta_temperature_convert;
	import ntc_pkg::*;

	localparam int FULL       = DEFAULT_FULL_SCALE;
	localparam int DRAIN_CYC  = 50;
	localparam int WDOG_LIMIT = 4000;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [SAMPLE_W-1:0]      sample_ch0;
	logic [SAMPLE_W-1:0]      sample_ch1;
	logic                     done;
	logic signed [TEMP_W-1:0] temp_ch0;
	logic                     valid_ch0;
	logic signed [TEMP_W-1:0] temp_ch1;
	logic                     valid_ch1;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;

	typedef struct {
		lane_res_t ch0;
		lane_res_t ch1;
	} temp_word_t;

	temp_word_t   temp_expected_q[$];
	int           errors;
	int           idle_cycles = 0;

	logic [BETA_W-1:0] m_beta;
	logic [RES_W-1:0]  m_r0;
	logic [T0_W-1:0]   m_t0;
	logic [RES_W-1:0]  m_rs;
	logic              m_en0;
	logic              m_en1;

	ntc_beta_temperature_convert u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_ch0(sample_ch0), .sample_ch1(sample_ch1), .done(done),
		.temp_ch0(temp_ch0), .valid_ch0(valid_ch0),
		.temp_ch1(temp_ch1), .valid_ch1(valid_ch1),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic longint log2_q16(longint unsigned x);
		longint unsigned m;
		longint          r;
		int              e;
		if (x == 0) return 0;
		e = 0;
		for (int b = 0; b < 32; b++) if (x[b]) e = b;
		m = x << (30 - e);
		r = longint'(e) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				r = r | (64'd1 << i);
			end
		end
		return r;
	endfunction

	function automatic lane_res_t beta_temp(int unsigned a, logic en);
		lane_res_t       res;
		longint          l2, lnq, d, n, tc;
		longint unsigned mag, lnmag;
		if (!en || a == 0 || a >= FULL || m_beta == 0 || m_r0 == 0 || m_t0 == 0 ||
				m_rs == 0) begin
			res.temp = TEMP_INVALID;
			res.vld  = 1'b0;
			return res;
		end
		l2 = log2_q16(64'(m_rs)) + log2_q16(64'(a)) - log2_q16(64'(FULL - a))
			- log2_q16(64'(m_r0));
		mag = (l2 < 0) ? -l2 : l2;
		lnmag = (mag * 64'd2977044472 + (64'd1 << 31)) >> 32;
		lnq = (l2 < 0) ? -longint'(lnmag) : longint'(lnmag);
		d = 100 * longint'(m_beta) * 65536 + longint'(m_t0) * lnq;
		res.vld = 1'b1;
		if (d <= 0) begin
			res.temp = TEMP_MAX;
		end else begin
			n = 100 * longint'(m_t0) * longint'(m_beta) * 65536;
			tc = (n + d / 2) / d;
			if (tc > 127315) res.temp = TEMP_MAX;
			else res.temp = TEMP_W'(tc - 27315);
		end
		return res;
	endfunction

	task automatic send_word(logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s1);
		int         gap;
		temp_word_t w;
		gap = $urandom_range(0, 11);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start      = 1'b1;
		sample_ch0 = s0;
		sample_ch1 = s1;
		do @(posedge clk); while (busy);
		w.ch0 = beta_temp(32'(s0), m_en0);
		w.ch1 = beta_temp(32'(s1), m_en1);
		temp_expected_q.push_back(w);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		start = 1'b0;
		wait (temp_expected_q.size() == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_BETA: m_beta = data[BETA_W-1:0];
			REG_R0:   m_r0   = data[RES_W-1:0];
			REG_T0:   m_t0   = data[T0_W-1:0];
			REG_RS:   m_rs   = data[RES_W-1:0];
			REG_EN0:  m_en0  = data[0];
			REG_EN1:  m_en1  = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_regs(int beta, int r0, int t0, int rs, bit e0, bit e1);
		write_reg(REG_BETA, CFG_DATA_W'(beta));
		write_reg(REG_R0, CFG_DATA_W'(r0));
		write_reg(REG_T0, CFG_DATA_W'(t0));
		write_reg(REG_RS, CFG_DATA_W'(rs));
		write_reg(REG_EN0, CFG_DATA_W'(e0));
		write_reg(REG_EN1, CFG_DATA_W'(e1));
	endtask

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SAMPLE_W'(FULL);
			2: return SAMPLE_W'($urandom_range(1, 3));
			3: return SAMPLE_W'($urandom_range(FULL - 3, FULL - 1));
			default: return SAMPLE_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic test_directed_defaults();
		logic [SAMPLE_W-1:0] edges[8] = '{0, 1, 2, 2047, 2048, 4093, 4094, 4095};
		foreach (edges[i]) send_word(edges[i], edges[7-i]);
		send_word(12'hAAA, 12'h555);
		send_word(12'h555, 12'hAAA);
	endtask

	task automatic test_enables();
		set_regs(3950, 10000, 29815, 10000, 1'b0, 1'b1);
		send_word(2048, 2048);
		send_word(100, 4000);
		write_reg(REG_EN0, CFG_DATA_W'(1));
		write_reg(REG_EN1, CFG_DATA_W'(0));
		send_word(2048, 2048);
		write_reg(REG_EN0, CFG_DATA_W'(0));
		send_word(1000, 3000);
	endtask

	task automatic test_register_extremes();
		set_regs(0, 10000, 29815, 10000, 1'b1, 1'b1);
		send_word(2048, 1);
		set_regs(3950, 0, 0, 0, 1'b1, 1'b1);
		send_word(2048, 4094);
		set_regs(1, 1000000, 65535, 1, 1'b1, 1'b1);
		send_word(1, 4094);
		send_word(2048, 100);
		set_regs(65535, 1, 1, 1000000, 1'b1, 1'b1);
		send_word(1, 4094);
		send_word(2048, 3);
		set_regs(1, 1, 65535, 1000000, 1'b1, 1'b1);
		send_word(4094, 2048);
		write_reg(cfg_reg_t'(6), 20'hFFFFF);
		write_reg(cfg_reg_t'(7), 20'h00000);
		send_word(4094, 1);
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 16; p++) begin
			if (p == 0) set_regs(3950, 10000, 29815, 10000, 1'b1, 1'b1);
			else if (p == 1) set_regs(65535, 1000000, 65535, 1000000, 1'b1, 1'b1);
			else if (p == 2) set_regs(1, 1, 1, 1, 1'b1, 1'b1);
			else set_regs($urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
				$urandom_range(0, 20'hFFFFF), $urandom_range(0, 20'hFFFFF),
				($urandom_range(0, 7) != 0), ($urandom_range(0, 7) != 0));
			for (int i = 0; i < 100; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					for (int k = 0; k < 12; k++) begin
						start      = 1'b1;
						sample_ch0 = rand_sample();
						sample_ch1 = rand_sample();
						do @(posedge clk); while (busy);
						temp_expected_q.push_back('{beta_temp(32'(sample_ch0), m_en0),
							beta_temp(32'(sample_ch1), m_en1)});
						@(negedge clk);
						i++;
					end
				end else begin
					send_word(rand_sample(), rand_sample());
				end
			end
		end
	endtask

	always @(posedge clk) begin
		temp_word_t w;
		if (arst_n && done) begin
			if (temp_expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				w = temp_expected_q.pop_front();
				if (temp_ch0 !== w.ch0.temp) begin
					$error("temp_ch0 exp %0d got %0d", w.ch0.temp, temp_ch0); errors++;
				end
				if (valid_ch0 !== w.ch0.vld) begin
					$error("valid_ch0 exp %0b got %0b", w.ch0.vld, valid_ch0); errors++;
				end
				if (temp_ch1 !== w.ch1.temp) begin
					$error("temp_ch1 exp %0d got %0d", w.ch1.temp, temp_ch1); errors++;
				end
				if (valid_ch1 !== w.ch1.vld) begin
					$error("valid_ch1 exp %0b got %0b", w.ch1.vld, valid_ch1); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("tb_ntc_beta_temperature_convert NOT OK");
			$finish;
		end
	end

	initial begin
		errors      = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		sample_ch0  = '0;
		sample_ch1  = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		m_beta = 3950; m_r0 = 10000; m_t0 = 29815; m_rs = 10000; m_en0 = 1; m_en1 = 1;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_defaults();
		test_enables();
		test_register_extremes();
		test_random_phases();

		start = 1'b0;
		wait (temp_expected_q.size() == 0);
		repeat (DRAIN_CYC) @(negedge clk);
		if (errors == 0)
			$display("tb_ntc_beta_temperature_convert OK");
		else
			$display("tb_ntc_beta_temperature_convert NOT OK");
		$finish;
	end

endmodule
